// ----- src/rfp_pkg.sv -----
// rfp_pkg: shared types and constants for the ring FIFO with peek.
// Holds the operation and status codes and the input and result word structs.
// Depends on nothing; used by ring_fifo_with_peek.
package rfp_pkg;

    // Default sizing handed to the top level's parameters.
    localparam int DEFAULT_MAX_SLOTS   = 256;
    localparam int DEFAULT_ENTRY_WIDTH = 32;

    // Slot count after reset and the smallest legal slot count.
    localparam int SLOT_COUNT_RESET = 256;
    localparam int SLOT_COUNT_MIN   = 2;

    // Fixed field widths of the channels.
    localparam int MODE_W       = 2;
    localparam int DATA_W       = 32;
    localparam int OFFSET_W     = 8;
    localparam int STATUS_W     = 2;
    localparam int USED_W       = 8;
    localparam int SLOT_COUNT_W = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 2'd0,
        MODE_GET   = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        mode_t                mode;
        logic [DATA_W-1:0]    write_data;
        logic [OFFSET_W-1:0]  offset;
    } in_word_t;

    typedef struct packed {
        status_t              status;
        logic [DATA_W-1:0]    read_data;
        logic [USED_W-1:0]    used_count;
    } out_word_t;

endpackage

// ----- src/rfp_slot_ram.sv -----
// rfp_slot_ram: slot storage of the ring FIFO, one write and one read port.
// Synchronous memory with registered read data.
// Depends on nothing; instantiated by ring_fifo_with_peek.
module rfp_slot_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds between reads, so a stalled result keeps its entry.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/ring_fifo_with_peek.sv -----
// ring_fifo_with_peek: top level of the ring FIFO with peek-at-offset.
// Depends on rfp_pkg for types and codes and on rfp_slot_ram for storage.
//
// Usage
// The input channel (s_valid, s_ready, s_data) carries one operation word:
// put, get, peek at an offset from the oldest entry, or clear. Every input
// word produces exactly one result word on the output channel (m_valid,
// m_ready, m_data) with a status code, the data read by a successful get or
// peek (zero otherwise) and the number of entries held after the operation.
// The ring keeps one slot empty, so it holds up to slot_count - 1 entries.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the slot
// count; values below 2 act as 2 and values above MAX_SLOTS act as MAX_SLOTS.
// A configuration write empties the ring; it must only be issued while idle,
// which the block itself does not enforce. From input acceptance a result
// passes the synchronous slot memory read, then the output register.
// Throughput is one word per cycle; the head and tail indices update in the
// accept cycle, so the next word sees them at once, and each word touches the
// memory on only one port. When the receiver stalls, the result waits in the
// output register and one more word can sit in the read stage behind it;
// s_ready falls only when both are full. Reset empties the ring and sets the
// slot count to 256 (capped at MAX_SLOTS); no clearing pass is needed since
// entries are only read after a put wrote them.
module ring_fifo_with_peek #(
    parameter int MAX_SLOTS   = rfp_pkg::DEFAULT_MAX_SLOTS,
    parameter int ENTRY_WIDTH = rfp_pkg::DEFAULT_ENTRY_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  rfp_pkg::in_word_t                   s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output rfp_pkg::out_word_t                  m_data,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rfp_pkg::SLOT_COUNT_W-1:0]    cfg_data
);

    // Index width covers slots 0..MAX_SLOTS-1; size width holds MAX_SLOTS.
    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int SIZE_W = $clog2(MAX_SLOTS + 1);
    // Width for head plus peek offset before the wrap.
    localparam int SUM_W  = ((IDX_W > rfp_pkg::OFFSET_W) ? IDX_W : rfp_pkg::OFFSET_W) + 1;
    localparam int RESET_SIZE = (rfp_pkg::SLOT_COUNT_RESET > MAX_SLOTS) ?
                                MAX_SLOTS : rfp_pkg::SLOT_COUNT_RESET;

    // Ring control state.
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    // Read stage: result fields waiting for the memory read data.
    logic                           a_valid_reg, a_valid_next;
    rfp_pkg::status_t               a_status_reg, a_status_next;
    logic [rfp_pkg::USED_W-1:0]     a_used_reg, a_used_next;
    logic                           a_rd_reg, a_rd_next;

    // Output register.
    logic                           m_valid_reg, m_valid_next;
    rfp_pkg::out_word_t             m_data_reg, m_data_next;

    // Handshakes.
    logic in_fire;
    logic cfg_fire;
    logic a_move;

    // Operation decode and index arithmetic.
    logic [SIZE_W-1:0] used;
    logic [SIZE_W-1:0] used_after;
    logic [SIZE_W-1:0] tail_inc;
    logic [IDX_W-1:0]  tail_adv;
    logic [SIZE_W-1:0] head_inc;
    logic [IDX_W-1:0]  head_adv;
    logic [SUM_W-1:0]  peek_sum;
    logic [IDX_W-1:0]  peek_idx;
    logic [SUM_W-1:0]  offset_ext;
    logic [SUM_W-1:0]  used_ext;
    logic [31:0]       cfg_clamped;

    // Memory ports.
    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic [ENTRY_WIDTH-1:0] ram_wr_data;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [ENTRY_WIDTH-1:0] ram_rd_data;
    logic [63:0]            wr_wide;
    logic [63:0]            rd_wide;

    // The read stage frees when its word moves to the output register, so a
    // new word enters as long as either stage has room.
    assign a_move    = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !a_valid_reg || !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Entries in the ring: tail minus head, modulo the ring size.
    always_comb begin
        used = SIZE_W'(tail_reg) - SIZE_W'(head_reg);
        if (tail_reg < head_reg) begin
            used = used + size_reg;
        end
    end

    // Index advances by one, wrapping at the ring size.
    always_comb begin
        tail_inc = SIZE_W'(tail_reg) + SIZE_W'(1);
        if (tail_inc >= size_reg) begin
            tail_inc = '0;
        end
        tail_adv = tail_inc[IDX_W-1:0];

        head_inc = SIZE_W'(head_reg) + SIZE_W'(1);
        if (head_inc >= size_reg) begin
            head_inc = '0;
        end
        head_adv = head_inc[IDX_W-1:0];
    end

    // Peek address: head plus offset, one subtract brings it back into the
    // ring because a valid offset is below the used count.
    always_comb begin
        offset_ext = SUM_W'(s_data.offset);
        used_ext   = SUM_W'(used);
        peek_sum   = SUM_W'(head_reg) + offset_ext;
        if (peek_sum >= SUM_W'(size_reg)) begin
            peek_sum = peek_sum - SUM_W'(size_reg);
        end
        peek_idx = peek_sum[IDX_W-1:0];
    end

    // Slot count written on the configuration port, clamped to the legal range.
    always_comb begin
        cfg_clamped = 32'(cfg_data);
        if (cfg_clamped < 32'(rfp_pkg::SLOT_COUNT_MIN)) begin
            cfg_clamped = 32'(rfp_pkg::SLOT_COUNT_MIN);
        end else if (cfg_clamped > 32'(MAX_SLOTS)) begin
            cfg_clamped = 32'(MAX_SLOTS);
        end
    end

    // Operation decode: index updates, memory access and result fields.
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        size_next     = size_reg;
        used_after    = used;
        a_status_next = a_status_reg;
        a_used_next   = a_used_reg;
        a_rd_next     = a_rd_reg;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = head_reg;

        if (in_fire) begin
            a_status_next = rfp_pkg::STATUS_OK;
            a_rd_next     = 1'b0;
            case (s_data.mode)
                rfp_pkg::MODE_PUT: begin
                    if (tail_adv == head_reg) begin
                        a_status_next = rfp_pkg::STATUS_FULL;
                    end else begin
                        ram_wr_en  = 1'b1;
                        tail_next  = tail_adv;
                        used_after = used + SIZE_W'(1);
                    end
                end
                rfp_pkg::MODE_GET: begin
                    if (used == '0) begin
                        a_status_next = rfp_pkg::STATUS_EMPTY;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_reg;
                        a_rd_next   = 1'b1;
                        head_next   = head_adv;
                        used_after  = used - SIZE_W'(1);
                    end
                end
                rfp_pkg::MODE_PEEK: begin
                    if (used == '0) begin
                        a_status_next = rfp_pkg::STATUS_EMPTY;
                    end else if (offset_ext >= used_ext) begin
                        a_status_next = rfp_pkg::STATUS_RANGE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = peek_idx;
                        a_rd_next   = 1'b1;
                    end
                end
                rfp_pkg::MODE_CLEAR: begin
                    head_next  = '0;
                    tail_next  = '0;
                    used_after = '0;
                end
                default: begin
                    a_status_next = rfp_pkg::STATUS_OK;
                end
            endcase
            a_used_next = rfp_pkg::USED_W'(used_after);
        end

        // A slot count write re-initializes the ring.
        if (cfg_fire) begin
            head_next = '0;
            tail_next = '0;
            size_next = SIZE_W'(cfg_clamped);
        end
    end

    // Entries are cut or zero-extended between the 32-bit fields and the
    // stored entry width.
    assign wr_wide     = 64'(s_data.write_data);
    assign ram_wr_data = wr_wide[ENTRY_WIDTH-1:0];
    assign ram_wr_addr = tail_reg;
    assign rd_wide     = 64'(ram_rd_data);

    // Stage valid flags and the output word.
    always_comb begin
        a_valid_next = a_valid_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (a_move) begin
            m_valid_next          = 1'b1;
            m_data_next.status    = a_status_reg;
            m_data_next.read_data = a_rd_reg ? rd_wide[rfp_pkg::DATA_W-1:0] : '0;
            m_data_next.used_count = a_used_reg;
            a_valid_next          = 1'b0;
        end
        if (in_fire) begin
            a_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            size_reg    <= SIZE_W'(RESET_SIZE);
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            size_reg    <= size_next;
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        a_status_reg <= a_status_next;
        a_used_reg   <= a_used_next;
        a_rd_reg     <= a_rd_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    rfp_slot_ram #(
        .DEPTH  (MAX_SLOTS),
        .WIDTH  (ENTRY_WIDTH),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

`ifndef SYNTHESIS
    // Both indices always lie inside the ring.
    a_idx_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (SIZE_W'(head_reg) < size_reg) && (SIZE_W'(tail_reg) < size_reg))
        else $error("ring index beyond slot count");

    // A failed operation never returns read data.
    a_fail_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != rfp_pkg::STATUS_OK) |-> (m_data.read_data == '0))
        else $error("read data on a failed operation");

    // A slot count write leaves the ring empty.
    a_cfg_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> (head_reg == '0) && (tail_reg == '0))
        else $error("ring not empty after slot count write");

    // The memory is read only for a word entering the read stage.
    a_read_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_rd_en |-> in_fire)
        else $error("slot read without an accepted word");
`endif

endmodule
